/* rtl/ppmgs_pkg.sv */
package ppmgs_pkg;

    localparam int unsigned DIM_BITS_DEFAULT = 16;
    localparam int unsigned QUEUE_DEPTH      = 4;

    // Parser phases
    typedef enum logic [3:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_SKIP_W,
        PH_CMT_W,
        PH_NUM_W,
        PH_SKIP_H,
        PH_CMT_H,
        PH_NUM_H,
        PH_SKIP_M,
        PH_CMT_M,
        PH_NUM_M,
        PH_AFTER_CR,
        PH_PIXELS,
        PH_DONE,
        PH_ERROR
    } t_phase;

    // Result sequences that one input byte can cause
    typedef enum logic [2:0] {
        OP_ERROR,
        OP_HEADER,
        OP_HEADER_DONE,
        OP_HEADER_TRUNC,
        OP_GREY,
        OP_GREY_DONE
    } t_op;

    localparam logic [1:0] KIND_GREY     = 2'd0;
    localparam logic [1:0] KIND_HEADER   = 2'd1;
    localparam logic [1:0] KIND_FINISHED = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_NUMBER    = 3'd2;
    localparam logic [2:0] ERR_MAXVAL    = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [8:0] MAXVAL_LIMIT = 9'd255;
    localparam logic [8:0] MAXVAL_SAT   = 9'd256;

    // Luma weights in thousandths, with the rounding offset
    localparam int unsigned SUM_W      = 18;
    localparam logic [9:0]  LUMA_R     = 10'd299;
    localparam logic [9:0]  LUMA_G     = 10'd587;
    localparam logic [9:0]  LUMA_B     = 10'd114;
    localparam logic [9:0]  LUMA_ROUND = 10'd500;

    // Division by 1000 as multiplication by ceil(2^28 / 1000); exact for sums below 2^18.
    localparam int unsigned RECIP_SHIFT = 28;
    localparam int unsigned PROD_W      = 37;
    localparam logic [18:0] RECIP_K     = 19'd268436;

    typedef struct packed {
        t_op              op;
        logic [2:0]       err;
        logic [SUM_W-1:0] sum;
        logic [7:0]       maxval;
        logic [15:0]      width;
        logic [15:0]      height;
    } t_cmd;

endpackage

/* rtl/ppmgs_front.sv */
module ppmgs_front
    import ppmgs_pkg::*;
#(
    parameter int unsigned DIM_BITS = DIM_BITS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    input  logic [7:0] i_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int unsigned ACC_W = DIM_BITS + 1;
    localparam int unsigned DW    = DIM_BITS + 4;
    localparam int unsigned PIX_W = 2 * DIM_BITS;
    localparam logic [DW-1:0] DIM_MAX = {4'b0000, {DIM_BITS{1'b1}}};

    t_phase              r_phase, n_phase;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [DIM_BITS-1:0] r_width, n_width;
    logic [DIM_BITS-1:0] r_height, n_height;
    logic [7:0]          r_maxval, n_maxval;
    logic [PIX_W-1:0]    r_pix, n_pix;
    logic [1:0]          r_chan, n_chan;
    logic [7:0]          r_red, n_red;
    logic [7:0]          r_green, n_green;

    logic                w_take;
    logic                w_space, w_hash, w_digit, w_stray;
    logic [3:0]          w_dval;
    logic [DW-1:0]       w_dim_acc;
    logic                w_dim_ovf;
    logic [12:0]         w_max_acc;
    logic [8:0]          w_max_sat;
    logic                w_hdr_ok, w_dims_zero, w_pix_last;
    logic [SUM_W-1:0]    w_sum;
    logic                v_push;
    t_op                 v_op;
    logic [2:0]          v_err;

    assign o_ready = ~i_full;
    assign w_take  = i_valid & ~i_full;

    assign w_space = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
    assign w_hash  = (i_byte == CH_HASH);
    assign w_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_stray = ~w_space & ~w_hash & ~w_digit;
    assign w_dval  = i_byte[3:0];

    // Decimal accumulation: x * 10 + digit as two shifted adds.
    assign w_dim_acc = (DW'(r_acc[DIM_BITS-1:0]) << 3) + (DW'(r_acc[DIM_BITS-1:0]) << 1)
                     + DW'(w_dval);
    assign w_dim_ovf = w_dim_acc > DIM_MAX;
    assign w_max_acc = (13'(r_acc[8:0]) << 3) + (13'(r_acc[8:0]) << 1) + 13'(w_dval);
    assign w_max_sat = (w_max_acc > 13'(MAXVAL_SAT)) ? MAXVAL_SAT : w_max_acc[8:0];

    assign w_hdr_ok    = (r_acc != '0) && (r_acc <= ACC_W'(MAXVAL_LIMIT));
    assign w_dims_zero = (r_width == '0) || (r_height == '0);
    assign w_pix_last  = (r_pix == PIX_W'(1));

    assign w_sum = SUM_W'(LUMA_R) * SUM_W'(r_red) + SUM_W'(LUMA_G) * SUM_W'(r_green)
                 + SUM_W'(LUMA_B) * SUM_W'(i_byte) + SUM_W'(LUMA_ROUND);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (w_take) begin
            if (i_action) begin
                n_phase = PH_MAGIC0;
            end else begin
                unique case (r_phase)
                    PH_MAGIC0: n_phase = (i_byte == CH_P) ? PH_MAGIC1 : PH_ERROR;
                    PH_MAGIC1: n_phase = (i_byte == CH_SIX) ? PH_SKIP_W : PH_ERROR;
                    PH_SKIP_W: begin
                        if (w_hash)       n_phase = PH_CMT_W;
                        else if (w_digit) n_phase = PH_NUM_W;
                        else if (w_stray) n_phase = PH_ERROR;
                    end
                    PH_SKIP_H: begin
                        if (w_hash)       n_phase = PH_CMT_H;
                        else if (w_digit) n_phase = PH_NUM_H;
                        else if (w_stray) n_phase = PH_ERROR;
                    end
                    PH_SKIP_M: begin
                        if (w_hash)       n_phase = PH_CMT_M;
                        else if (w_digit) n_phase = PH_NUM_M;
                        else if (w_stray) n_phase = PH_ERROR;
                    end
                    PH_CMT_W: if (i_byte == CH_LF) n_phase = PH_SKIP_W;
                    PH_CMT_H: if (i_byte == CH_LF) n_phase = PH_SKIP_H;
                    PH_CMT_M: if (i_byte == CH_LF) n_phase = PH_SKIP_M;
                    PH_NUM_W: begin
                        if (w_digit)      n_phase = w_dim_ovf ? PH_ERROR : PH_NUM_W;
                        else if (w_hash)  n_phase = PH_CMT_H;
                        else if (w_space) n_phase = PH_SKIP_H;
                        else              n_phase = PH_ERROR;
                    end
                    PH_NUM_H: begin
                        if (w_digit)      n_phase = w_dim_ovf ? PH_ERROR : PH_NUM_H;
                        else if (w_hash)  n_phase = PH_CMT_M;
                        else if (w_space) n_phase = PH_SKIP_M;
                        else              n_phase = PH_ERROR;
                    end
                    PH_NUM_M: begin
                        if (w_digit)                n_phase = PH_NUM_M;
                        else if (!w_hdr_ok)         n_phase = PH_ERROR;
                        else if (w_dims_zero)       n_phase = PH_DONE;
                        else if (i_byte == CH_CR)   n_phase = PH_AFTER_CR;
                        else                        n_phase = PH_PIXELS;
                    end
                    PH_AFTER_CR: n_phase = PH_PIXELS;
                    PH_PIXELS: begin
                        if ((r_chan == 2'd2) && w_pix_last) n_phase = PH_DONE;
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    // Datapath registers and queue entry
    always_comb begin
        n_acc    = r_acc;
        n_width  = r_width;
        n_height = r_height;
        n_maxval = r_maxval;
        n_pix    = r_pix;
        n_chan   = r_chan;
        n_red    = r_red;
        n_green  = r_green;
        v_push   = 1'b0;
        v_op     = OP_ERROR;
        v_err    = ERR_NONE;
        if (w_take) begin
            if (i_action) begin
                if (r_phase == PH_NUM_M) begin
                    v_push = 1'b1;
                    if (!w_hdr_ok) begin
                        v_err = ERR_MAXVAL;
                    end else begin
                        n_maxval = r_acc[7:0];
                        v_op     = w_dims_zero ? OP_HEADER_DONE : OP_HEADER_TRUNC;
                        v_err    = w_dims_zero ? ERR_NONE : ERR_TRUNCATED;
                    end
                end else if ((r_phase != PH_DONE) && (r_phase != PH_ERROR)) begin
                    v_push = 1'b1;
                    v_err  = ERR_TRUNCATED;
                end
            end else begin
                unique case (r_phase)
                    PH_MAGIC0: begin
                        if (i_byte != CH_P) begin
                            v_push = 1'b1;
                            v_err  = ERR_MAGIC;
                        end
                    end
                    PH_MAGIC1: begin
                        if (i_byte != CH_SIX) begin
                            v_push = 1'b1;
                            v_err  = ERR_MAGIC;
                        end
                    end
                    PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
                        if (w_digit) begin
                            n_acc = ACC_W'(w_dval);
                        end else if (w_stray) begin
                            v_push = 1'b1;
                            v_err  = ERR_NUMBER;
                        end
                    end
                    PH_NUM_W, PH_NUM_H: begin
                        if (w_digit) begin
                            n_acc = ACC_W'(w_dim_acc);
                            if (w_dim_ovf) begin
                                v_push = 1'b1;
                                v_err  = ERR_NUMBER;
                            end
                        end else begin
                            if (r_phase == PH_NUM_W) n_width  = r_acc[DIM_BITS-1:0];
                            else                     n_height = r_acc[DIM_BITS-1:0];
                            if (!w_space && !w_hash) begin
                                v_push = 1'b1;
                                v_err  = ERR_NUMBER;
                            end
                        end
                    end
                    PH_NUM_M: begin
                        if (w_digit) begin
                            n_acc = ACC_W'(w_max_sat);
                        end else if (!w_hdr_ok) begin
                            v_push = 1'b1;
                            v_err  = ERR_MAXVAL;
                        end else begin
                            n_maxval = r_acc[7:0];
                            n_pix    = PIX_W'(r_width) * PIX_W'(r_height);
                            n_chan   = 2'd0;
                            v_push   = 1'b1;
                            v_op     = w_dims_zero ? OP_HEADER_DONE : OP_HEADER;
                            // A byte that ends maxval and is not whitespace is the first red.
                            if (!w_dims_zero && !w_space) begin
                                n_red  = i_byte;
                                n_chan = 2'd1;
                            end
                        end
                    end
                    PH_AFTER_CR: begin
                        if (i_byte != CH_LF) begin
                            n_red  = i_byte;
                            n_chan = 2'd1;
                        end
                    end
                    PH_PIXELS: begin
                        case (r_chan)
                            2'd0: begin
                                n_red  = i_byte;
                                n_chan = 2'd1;
                            end
                            2'd1: begin
                                n_green = i_byte;
                                n_chan  = 2'd2;
                            end
                            default: begin
                                n_chan = 2'd0;
                                n_pix  = r_pix - PIX_W'(1);
                                v_push = 1'b1;
                                v_op   = w_pix_last ? OP_GREY_DONE : OP_GREY;
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
        end

        o_push        = v_push;
        o_cmd.op      = v_op;
        o_cmd.err     = v_err;
        o_cmd.sum     = w_sum;
        o_cmd.maxval  = n_maxval;
        o_cmd.width   = 16'(n_width);
        o_cmd.height  = 16'(n_height);

        // End of input returns everything to its reset value once the reports are built.
        if (w_take && i_action) begin
            n_acc    = '0;
            n_width  = '0;
            n_height = '0;
            n_maxval = '0;
            n_pix    = '0;
            n_chan   = '0;
            n_red    = '0;
            n_green  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC0;
            r_acc    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_maxval <= '0;
            r_pix    <= '0;
            r_chan   <= '0;
            r_red    <= '0;
            r_green  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_width  <= n_width;
            r_height <= n_height;
            r_maxval <= n_maxval;
            r_pix    <= n_pix;
            r_chan   <= n_chan;
            r_red    <= n_red;
            r_green  <= n_green;
        end
    end

endmodule

/* rtl/ppmgs_queue.sv */
module ppmgs_queue
    import ppmgs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/ppmgs_back.sv */
module ppmgs_back
    import ppmgs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_cmd        i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_grey,
    output logic [15:0] o_width,
    output logic [15:0] o_height,
    output logic [7:0]  o_maxval,
    output logic [2:0]  o_err,
    output logic        o_last
);

    logic              r_valid;
    logic [1:0]        r_idx;
    logic [1:0]        r_kind;
    logic [7:0]        r_grey;
    logic [15:0]       r_width;
    logic [15:0]       r_height;
    logic [7:0]        r_maxval;
    logic [2:0]        r_err;
    logic              r_last;

    logic [PROD_W-1:0] w_prod;
    logic [7:0]        w_luma, w_clamped;
    logic [1:0]        w_last_idx;
    logic [1:0]        w_kind;
    logic [2:0]        w_err;
    logic              w_load, w_is_last;

    assign w_prod    = PROD_W'(i_head.sum) * PROD_W'(RECIP_K);
    assign w_luma    = w_prod[RECIP_SHIFT +: 8];
    assign w_clamped = (w_luma > i_head.maxval) ? i_head.maxval : w_luma;

    // Which result of the head entry's sequence is next.
    always_comb begin
        w_last_idx = 2'd0;
        w_kind     = KIND_ERROR;
        w_err      = ERR_NONE;
        unique case (i_head.op)
            OP_ERROR: begin
                w_kind = KIND_ERROR;
                w_err  = i_head.err;
            end
            OP_HEADER: begin
                w_kind = KIND_HEADER;
            end
            OP_HEADER_DONE: begin
                w_last_idx = 2'd1;
                w_kind     = (r_idx == 2'd0) ? KIND_HEADER : KIND_FINISHED;
            end
            OP_HEADER_TRUNC: begin
                w_last_idx = 2'd1;
                if (r_idx == 2'd0) begin
                    w_kind = KIND_HEADER;
                end else begin
                    w_kind = KIND_ERROR;
                    w_err  = i_head.err;
                end
            end
            OP_GREY: begin
                w_last_idx = 2'd2;
                w_kind     = KIND_GREY;
            end
            OP_GREY_DONE: begin
                w_last_idx = 2'd3;
                w_kind     = (r_idx == 2'd3) ? KIND_FINISHED : KIND_GREY;
            end
            default: begin
                w_kind = KIND_ERROR;
                w_err  = i_head.err;
            end
        endcase
    end

    assign w_load    = i_head_valid && (!r_valid || i_ready);
    assign w_is_last = (r_idx == w_last_idx);
    assign o_pop     = w_load && w_is_last;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind   <= w_kind;
            r_grey   <= (w_kind == KIND_GREY) ? w_clamped : 8'd0;
            r_width  <= i_head.width;
            r_height <= i_head.height;
            r_maxval <= i_head.maxval;
            r_err    <= w_err;
            r_last   <= w_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_is_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_kind   = r_kind;
    assign o_grey   = r_grey;
    assign o_width  = r_width;
    assign o_height = r_height;
    assign o_maxval = r_maxval;
    assign o_err    = r_err;
    assign o_last   = r_last;

endmodule

/* rtl/ppm_p6_greyscale_stream.sv */
// A byte that causes results is written into the queue when it is accepted, and its first
// result is then loaded from the queue head into the output register on the master side.
// Throughput: one input byte per cycle while the queue is not full, one result per cycle
// while the master is ready; a four-entry queue between parser and sequencer absorbs extra reports.
// Reset: synchronous, active low; the parser expects the magic and the queue is empty.
module ppm_p6_greyscale_stream
    import ppmgs_pkg::*;
#(
    parameter int unsigned DIM_BITS = DIM_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [7:0] grey_value, [23:8] image_width,
                                        // [39:24] image_height, [47:40] max_level,
                                        // [50:48] error_code, [55:51] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    logic        w_push, w_full, w_pop, w_head_valid;
    t_cmd        w_cmd, w_head;
    logic [7:0]  w_grey, w_maxval;
    logic [15:0] w_width, w_height;
    logic [2:0]  w_err;

    ppmgs_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_action (s_axis_tuser[0]),
        .i_byte   (s_axis_tdata),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd)
    );

    ppmgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    ppmgs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_kind       (m_axis_tuser),
        .o_grey       (w_grey),
        .o_width      (w_width),
        .o_height     (w_height),
        .o_maxval     (w_maxval),
        .o_err        (w_err),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, w_err, w_maxval, w_height, w_width, w_grey};

endmodule
